>>> rtl/cmfs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cmfs_pkg
// Shared types and constants for cube-map face selection.
// ============================================================================
package cmfs_pkg;

    localparam int FACE_W = 3;

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

endpackage

>>> rtl/cube_map_face_select.sv
`timescale 1ns / 1ps
// ============================================================================
// cube_map_face_select
// Major-axis cube face selection with per-face (s, t) position, pipelined.
// ============================================================================
// Takes one direction beat per cycle and returns one face beat per beat, in
// order. The pipeline is one stage for component magnitudes, one for the
// major-axis compare, one for the numerators, FRAC_BITS + 2 restoring divider
// stages (one quotient bit each, both coordinates in parallel lanes), then a
// two-entry output buffer that rounds the quotient on entry. Sustained rate is
// one beat per cycle while the output buffer has room; the divider chain sets
// the depth. The pipeline moves as a whole and stalls only while the output
// buffer is full, so o_ready does not depend on i_ready in the same cycle. A
// zero vector gives +X at (0.5, 0.5).
module cube_map_face_select #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [COORD_WIDTH-1:0]         i_dir_x,
    input  logic signed [COORD_WIDTH-1:0]         i_dir_y,
    input  logic signed [COORD_WIDTH-1:0]         i_dir_z,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [cmfs_pkg::FACE_W-1:0]           o_face,
    output logic [FRAC_BITS:0]                    o_face_s,
    output logic [FRAC_BITS:0]                    o_face_t
);

    localparam int W         = COORD_WIDTH;
    localparam int DIV_STEPS = FRAC_BITS + 2;
    localparam int QW        = FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);

    logic en;

    // ---------------- stage 1: sign extend, negate, magnitude ----------------
    logic                r1_vld;
    logic signed [W:0]   r1_x, r1_y, r1_z;
    logic signed [W:0]   r1_nx, r1_ny, r1_nz;
    logic [W-1:0]        r1_ax, r1_ay, r1_az;
    logic signed [W:0]   n1_x, n1_y, n1_z;
    logic signed [W:0]   n1_nx, n1_ny, n1_nz;

    always_comb begin
        n1_x  = $signed({i_dir_x[W-1], i_dir_x});
        n1_y  = $signed({i_dir_y[W-1], i_dir_y});
        n1_z  = $signed({i_dir_z[W-1], i_dir_z});
        n1_nx = -n1_x;
        n1_ny = -n1_y;
        n1_nz = -n1_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x  <= n1_x;
            r1_y  <= n1_y;
            r1_z  <= n1_z;
            r1_nx <= n1_nx;
            r1_ny <= n1_ny;
            r1_nz <= n1_nz;
            // magnitude of the most negative value still fits in W bits
            r1_ax <= i_dir_x[W-1] ? n1_nx[W-1:0] : i_dir_x;
            r1_ay <= i_dir_y[W-1] ? n1_ny[W-1:0] : i_dir_y;
            r1_az <= i_dir_z[W-1] ? n1_nz[W-1:0] : i_dir_z;
        end
    end

    // ---------------- stage 2: major axis, face, sc/tc ----------------
    logic                r2_vld;
    cmfs_pkg::t_face     r2_face, n2_face;
    logic [W-1:0]        r2_ma, n2_ma;
    logic signed [W:0]   r2_sc, r2_tc, n2_sc, n2_tc;

    always_comb begin
        if (r1_ax >= r1_ay && r1_ax >= r1_az) begin
            n2_ma = r1_ax;
            n2_tc = r1_ny;
            if (!r1_x[W]) begin
                n2_face = cmfs_pkg::FACE_POS_X;
                n2_sc   = r1_nz;
            end else begin
                n2_face = cmfs_pkg::FACE_NEG_X;
                n2_sc   = r1_z;
            end
        end else if (r1_ay >= r1_az) begin
            n2_ma = r1_ay;
            n2_sc = r1_x;
            if (!r1_y[W]) begin
                n2_face = cmfs_pkg::FACE_POS_Y;
                n2_tc   = r1_z;
            end else begin
                n2_face = cmfs_pkg::FACE_NEG_Y;
                n2_tc   = r1_nz;
            end
        end else begin
            n2_ma = r1_az;
            n2_tc = r1_ny;
            if (!r1_z[W]) begin
                n2_face = cmfs_pkg::FACE_POS_Z;
                n2_sc   = r1_x;
            end else begin
                n2_face = cmfs_pkg::FACE_NEG_Z;
                n2_sc   = r1_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_face <= n2_face;
            r2_ma   <= n2_ma;
            r2_sc   <= n2_sc;
            r2_tc   <= n2_tc;
        end
    end

    // ---------------- stage 3: numerators c + ma, divisor 2 ma ----------------
    logic                r3_vld;
    cmfs_pkg::t_face     r3_face;
    logic                r3_zero;
    logic [W:0]          r3_ns, r3_nt, r3_dv;
    logic signed [W+1:0] n3_ns, n3_nt;

    always_comb begin
        n3_ns = $signed({r2_sc[W], r2_sc}) + $signed({2'b00, r2_ma});
        n3_nt = $signed({r2_tc[W], r2_tc}) + $signed({2'b00, r2_ma});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_face <= r2_face;
            r3_zero <= (r2_ma == '0);
            r3_ns   <= n3_ns[W:0];   // 0 .. 2 ma, never negative
            r3_nt   <= n3_nt[W:0];
            r3_dv   <= {r2_ma, 1'b0};
        end
    end

    // ---------------- divider stages: one quotient bit each ----------------
    // q' = floor(n * 2^(F+1) / (2 ma)); first step is the integer bit.
    logic                r_vld  [DIV_STEPS];
    cmfs_pkg::t_face     r_face [DIV_STEPS];
    logic                r_zero [DIV_STEPS];
    logic [W:0]          r_dv   [DIV_STEPS];
    logic [W:0]          r_rem_s[DIV_STEPS];
    logic [W:0]          r_rem_t[DIV_STEPS];
    logic [QW-1:0]       r_quo_s[DIV_STEPS];
    logic [QW-1:0]       r_quo_t[DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_div
            logic                p_vld;
            cmfs_pkg::t_face     p_face;
            logic                p_zero;
            logic [W:0]          p_dv;
            logic [W+1:0]        trial_s, trial_t;
            logic [W+1:0]        diff_s, diff_t;
            logic                ge_s, ge_t;
            logic [QW-1:0]       p_quo_s, p_quo_t;
            logic [W:0]          n_rem_s, n_rem_t;

            if (k == 0) begin : g_first
                assign p_vld   = r3_vld;
                assign p_face  = r3_face;
                assign p_zero  = r3_zero;
                assign p_dv    = r3_dv;
                assign trial_s = {1'b0, r3_ns};
                assign trial_t = {1'b0, r3_nt};
                assign p_quo_s = '0;
                assign p_quo_t = '0;
            end else begin : g_next
                assign p_vld   = r_vld[k-1];
                assign p_face  = r_face[k-1];
                assign p_zero  = r_zero[k-1];
                assign p_dv    = r_dv[k-1];
                assign trial_s = {r_rem_s[k-1], 1'b0};
                assign trial_t = {r_rem_t[k-1], 1'b0};
                assign p_quo_s = r_quo_s[k-1];
                assign p_quo_t = r_quo_t[k-1];
            end

            always_comb begin
                diff_s  = trial_s - {1'b0, p_dv};
                diff_t  = trial_t - {1'b0, p_dv};
                ge_s    = (trial_s >= {1'b0, p_dv});
                ge_t    = (trial_t >= {1'b0, p_dv});
                // remainder stays below the divisor
                n_rem_s = ge_s ? diff_s[W:0] : trial_s[W:0];
                n_rem_t = ge_t ? diff_t[W:0] : trial_t[W:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (en) begin
                    r_vld[k] <= p_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_face[k]  <= p_face;
                    r_zero[k]  <= p_zero;
                    r_dv[k]    <= p_dv;
                    r_rem_s[k] <= n_rem_s;
                    r_rem_t[k] <= n_rem_t;
                    r_quo_s[k] <= {p_quo_s[QW-2:0], ge_s};
                    r_quo_t[k] <= {p_quo_t[QW-2:0], ge_t};
                end
            end
        end
    endgenerate

    // ---------------- rounding into the output buffer ----------------
    // round half up: floor(x + 1/2) = (floor(2x) + 1) >> 1
    logic [QW-1:0]         rnd_s, rnd_t;
    logic [FRAC_BITS:0]    fin_s, fin_t;
    logic                  push, pop;

    always_comb begin
        rnd_s = r_quo_s[DIV_STEPS-1] + QW'(1);
        rnd_t = r_quo_t[DIV_STEPS-1] + QW'(1);
        fin_s = r_zero[DIV_STEPS-1] ? HALF : rnd_s[QW-1:1];
        fin_t = r_zero[DIV_STEPS-1] ? HALF : rnd_t[QW-1:1];
    end

    // two-entry output buffer; pipeline advances while it has room
    logic [1:0]                r_cnt, n_cnt;
    cmfs_pkg::t_face           r_h_face, n_h_face, r_b_face, n_b_face;
    logic [FRAC_BITS:0]        r_h_s, n_h_s, r_h_t, n_h_t;
    logic [FRAC_BITS:0]        r_b_s, n_b_s, r_b_t, n_b_t;

    assign en      = (r_cnt != 2'd2);
    assign o_ready = en;
    assign push    = en && r_vld[DIV_STEPS-1];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_cnt    = r_cnt;
        n_h_face = r_h_face;
        n_h_s    = r_h_s;
        n_h_t    = r_h_t;
        n_b_face = r_b_face;
        n_b_s    = r_b_s;
        n_b_t    = r_b_t;
        case (r_cnt)
            2'd0: begin
                if (push) begin
                    n_h_face = r_face[DIV_STEPS-1];
                    n_h_s    = fin_s;
                    n_h_t    = fin_t;
                    n_cnt    = 2'd1;
                end
            end
            2'd1: begin
                if (push && pop) begin
                    n_h_face = r_face[DIV_STEPS-1];
                    n_h_s    = fin_s;
                    n_h_t    = fin_t;
                end else if (push) begin
                    n_b_face = r_face[DIV_STEPS-1];
                    n_b_s    = fin_s;
                    n_b_t    = fin_t;
                    n_cnt    = 2'd2;
                end else if (pop) begin
                    n_cnt = 2'd0;
                end
            end
            2'd2: begin
                if (pop) begin
                    n_h_face = r_b_face;
                    n_h_s    = r_b_s;
                    n_h_t    = r_b_t;
                    n_cnt    = 2'd1;
                end
            end
            default: begin
                n_cnt = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_face <= n_h_face;
        r_h_s    <= n_h_s;
        r_h_t    <= n_h_t;
        r_b_face <= n_b_face;
        r_b_s    <= n_b_s;
        r_b_t    <= n_b_t;
    end

    assign o_valid  = (r_cnt != 2'd0);
    assign o_face   = r_h_face;
    assign o_face_s = r_h_s;
    assign o_face_t = r_h_t;

endmodule

>>> rtl/cmfs_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// cmfs_checker
// Port-level checks for the cube-map face selector, bound to the top level.
// ============================================================================
module cmfs_checker #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic [COORD_WIDTH-1:0]        i_dir_x,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [cmfs_pkg::FACE_W-1:0]   o_face,
    input logic [FRAC_BITS:0]            o_face_s,
    input logic [FRAC_BITS:0]            o_face_t
);

    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // no result beat straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_face)
            && $stable(o_face_s) && $stable(o_face_t)))
        else $error("output beat changed while stalled");

    // positions never exceed 1.0
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_face_s <= ONE && o_face_t <= ONE))
        else $error("face position above 1.0");

    // with the output buffer empty the input side is always open
    a_open_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    // the x component of an accepted direction beat must be known
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> !$isunknown(i_dir_x))
        else $error("unknown x component on accepted beat");

endmodule

bind cube_map_face_select cmfs_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_cmfs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_dir_x (i_dir_x),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_face  (o_face),
    .o_face_s(o_face_s),
    .o_face_t(o_face_t)
);
